// ===== src/mlscan_pkg.sv =====
// ---------------------------------------------------------------------------
// mlscan_pkg
// Shared defaults, status codes and type byte constants for the message
// length scanner.
// ---------------------------------------------------------------------------
package mlscan_pkg;

	localparam int NEST_DEPTH_DEF = 16;
	localparam int COUNT_BITS_DEF = 40;

	localparam int LEN_W = 40;
	localparam int CNT_W = 33;

	typedef enum logic [1:0] {
		STS_COMPLETE   = 2'd0,
		STS_INVALID    = 2'd1,
		STS_INCOMPLETE = 2'd2,
		STS_TOO_DEEP   = 2'd3
	} sts_t;

	localparam logic [7:0] T_POSFIX_MAX = 8'h7f;
	localparam logic [7:0] T_FIXARR     = 8'h90;
	localparam logic [7:0] T_FIXRAW     = 8'ha0;
	localparam logic [7:0] T_NIL        = 8'hc0;
	localparam logic [7:0] T_FALSE      = 8'hc2;
	localparam logic [7:0] T_TRUE       = 8'hc3;
	localparam logic [7:0] T_FLOAT      = 8'hca;
	localparam logic [7:0] T_DOUBLE     = 8'hcb;
	localparam logic [7:0] T_UINT8      = 8'hcc;
	localparam logic [7:0] T_UINT16     = 8'hcd;
	localparam logic [7:0] T_UINT32     = 8'hce;
	localparam logic [7:0] T_UINT64     = 8'hcf;
	localparam logic [7:0] T_INT8       = 8'hd0;
	localparam logic [7:0] T_INT16      = 8'hd1;
	localparam logic [7:0] T_INT32      = 8'hd2;
	localparam logic [7:0] T_INT64      = 8'hd3;
	localparam logic [7:0] T_RAW16      = 8'hda;
	localparam logic [7:0] T_RAW32      = 8'hdb;
	localparam logic [7:0] T_ARR16      = 8'hdc;
	localparam logic [7:0] T_ARR32      = 8'hdd;
	localparam logic [7:0] T_MAP16      = 8'hde;
	localparam logic [7:0] T_MAP32      = 8'hdf;
	localparam logic [7:0] T_NEGFIX_MIN = 8'he0;

endpackage

// ===== src/msgpack_message_length_scanner_unit.sv =====
// ---------------------------------------------------------------------------
// msgpack_message_length_scanner_unit
// Scans one top-level object from a byte stream and reports its length or
// the reason it could not be measured.
// ---------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------
//  in      | in_valid / in_stall    | byte_value[7:0], last_byte
//  out     | out_valid / out_stall  | status[1:0], object_length[39:0]
//
// A byte is accepted only while in_stall is low. Each element end runs
// through the shared 33-bit decrementer, and each nesting level popped
// adds a stack read from the level memory, then a reload of the
// top-of-stack register. A result then waits in the emit stage while the
// output register still holds an unaccepted result; in_stall is high meanwhile.
// Reset is immediate; the level memory needs no clearing, only pushed
// entries are read. A stalled output holds while the next bytes are taken.
module msgpack_message_length_scanner_unit #(
	parameter int NEST_DEPTH = mlscan_pkg::NEST_DEPTH_DEF,
	parameter int COUNT_BITS = mlscan_pkg::COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 byte_value,
	input  logic                       last_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [mlscan_pkg::LEN_W-1:0] object_length
);

	localparam int LW = $clog2(NEST_DEPTH + 1);
	localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
	localparam int CW = mlscan_pkg::CNT_W;
	localparam int OW = mlscan_pkg::LEN_W;

	typedef enum logic [1:0] {S_IDLE, S_END, S_LOAD, S_EMIT} state_t;
	typedef enum logic [1:0] {PH_TYPE, PH_HEADER, PH_PAYLOAD, PH_DONE} phase_t;
	typedef enum logic [1:0] {HK_RAW, HK_ARR, HK_MAP} hkind_t;
	typedef enum logic [2:0] {
		ACT_NONE, ACT_ELEM, ACT_OPEN, ACT_PAYLOAD, ACT_HEADER, ACT_INVALID, ACT_IGNORE
	} act_t;

	state_t                state_q;
	phase_t                phase_q;
	hkind_t                hk_q;
	logic [2:0]            hbl_q;
	logic [31:0]           acc_q;
	logic [CW-1:0]         payload_q;
	logic [CW-1:0]         top_q;
	logic [LW-1:0]         level_q;
	logic [COUNT_BITS-1:0] bytes_q;
	logic                  last_q;
	mlscan_pkg::sts_t      res_sts_q;
	logic [OW-1:0]         res_len_q;
	logic                  out_valid_q;
	mlscan_pkg::sts_t      status_q;
	logic [OW-1:0]         object_length_q;

	logic [CW-1:0]         mem [NEST_DEPTH];
	logic [CW-1:0]         rdata_q;

	// shared decrementer
	logic [CW-1:0]         dec_in, dec_out;
	assign dec_in  = (state_q == S_END) ? top_q : payload_q;
	assign dec_out = dec_in - CW'(1);

	logic [COUNT_BITS-1:0] bytes_inc;
	assign bytes_inc = (&bytes_q) ? bytes_q : bytes_q + COUNT_BITS'(1);

	logic [COUNT_BITS+OW-1:0] bytes_ext;
	assign bytes_ext = {{OW{1'b0}}, bytes_q};

	logic [31:0] acc_new;
	logic [2:0]  hbl_new;
	assign acc_new = {acc_q[23:0], byte_value};
	assign hbl_new = hbl_q - 3'd1;

	// item decode
	act_t        act;
	logic [CW-1:0] act_n;
	hkind_t      new_hk;
	logic [2:0]  new_hbl;

	always_comb begin
		act     = ACT_NONE;
		act_n   = '0;
		new_hk  = HK_RAW;
		new_hbl = 3'd2;
		case (phase_q)
			PH_DONE: act = ACT_IGNORE;
			PH_HEADER: begin
				if (hbl_new == 3'd0) begin
					case (hk_q)
						HK_RAW: begin
							act   = ACT_PAYLOAD;
							act_n = {1'b0, acc_new};
						end
						HK_ARR: begin
							act   = ACT_OPEN;
							act_n = {1'b0, acc_new};
						end
						default: begin
							act   = ACT_OPEN;
							act_n = {acc_new, 1'b0};
						end
					endcase
				end
			end
			PH_PAYLOAD: begin
				if (dec_out == '0) act = ACT_ELEM;
			end
			default: begin
				if (byte_value <= mlscan_pkg::T_POSFIX_MAX
						|| byte_value >= mlscan_pkg::T_NEGFIX_MIN
						|| byte_value == mlscan_pkg::T_NIL
						|| byte_value == mlscan_pkg::T_FALSE
						|| byte_value == mlscan_pkg::T_TRUE) begin
					act = ACT_ELEM;
				end else if (byte_value < mlscan_pkg::T_FIXARR) begin
					act   = ACT_OPEN;
					act_n = CW'({byte_value[3:0], 1'b0});
				end else if (byte_value < mlscan_pkg::T_FIXRAW) begin
					act   = ACT_OPEN;
					act_n = CW'(byte_value[3:0]);
				end else if (byte_value < mlscan_pkg::T_NIL) begin
					act   = ACT_PAYLOAD;
					act_n = CW'(byte_value[4:0]);
				end else begin
					case (byte_value) inside
						mlscan_pkg::T_FLOAT, mlscan_pkg::T_UINT32, mlscan_pkg::T_INT32: begin
							act   = ACT_PAYLOAD;
							act_n = CW'(4);
						end
						mlscan_pkg::T_DOUBLE, mlscan_pkg::T_UINT64, mlscan_pkg::T_INT64: begin
							act   = ACT_PAYLOAD;
							act_n = CW'(8);
						end
						mlscan_pkg::T_UINT8, mlscan_pkg::T_INT8: begin
							act   = ACT_PAYLOAD;
							act_n = CW'(1);
						end
						mlscan_pkg::T_UINT16, mlscan_pkg::T_INT16: begin
							act   = ACT_PAYLOAD;
							act_n = CW'(2);
						end
						mlscan_pkg::T_RAW16, mlscan_pkg::T_RAW32: begin
							act     = ACT_HEADER;
							new_hk  = HK_RAW;
							new_hbl = byte_value[0] ? 3'd4 : 3'd2;
						end
						mlscan_pkg::T_ARR16, mlscan_pkg::T_ARR32: begin
							act     = ACT_HEADER;
							new_hk  = HK_ARR;
							new_hbl = byte_value[0] ? 3'd4 : 3'd2;
						end
						mlscan_pkg::T_MAP16, mlscan_pkg::T_MAP32: begin
							act     = ACT_HEADER;
							new_hk  = HK_MAP;
							new_hbl = byte_value[0] ? 3'd4 : 3'd2;
						end
						default: act = ACT_INVALID;
					endcase
				end
			end
		endcase
	end

	logic accept, n_zero, full, need_end, push, res_idle;
	mlscan_pkg::sts_t res_idle_sts;

	assign accept   = in_valid && !in_stall;
	assign n_zero   = (act_n == '0);
	assign full     = (level_q >= LW'(NEST_DEPTH));
	assign need_end = (act == ACT_ELEM)
		|| ((act == ACT_OPEN || act == ACT_PAYLOAD) && n_zero);
	assign push     = accept && act == ACT_OPEN && !n_zero && !full;

	always_comb begin
		res_idle     = 1'b0;
		res_idle_sts = mlscan_pkg::STS_INCOMPLETE;
		if (act == ACT_INVALID) begin
			res_idle     = 1'b1;
			res_idle_sts = mlscan_pkg::STS_INVALID;
		end else if (act == ACT_OPEN && !n_zero && full) begin
			res_idle     = 1'b1;
			res_idle_sts = mlscan_pkg::STS_TOO_DEEP;
		end else if (!need_end && act != ACT_IGNORE && last_byte) begin
			res_idle = 1'b1;
		end
	end

	// element end step
	logic end_done, end_pop;
	assign end_done = (level_q == '0) || (dec_out == '0 && level_q == LW'(1));
	assign end_pop  = (level_q > LW'(1)) && (dec_out == '0);

	logic [LW-1:0] lvl_m1, lvl_m2;
	assign lvl_m1 = level_q - LW'(1);
	assign lvl_m2 = level_q - LW'(2);

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	assign mem_we    = push && level_q != '0;
	assign mem_waddr = lvl_m1[AW-1:0];
	assign mem_re    = state_q == S_END && end_pop;
	assign mem_raddr = lvl_m2[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= top_q;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_TYPE;
			hk_q        <= HK_RAW;
			hbl_q       <= '0;
			acc_q       <= '0;
			payload_q   <= '0;
			level_q     <= '0;
			bytes_q     <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= last_byte;
						if (act != ACT_IGNORE) begin
							bytes_q <= bytes_inc;
							case (phase_q)
								PH_HEADER: begin
									acc_q <= acc_new;
									hbl_q <= hbl_new;
									if (hbl_new == 3'd0) phase_q <= PH_TYPE;
								end
								PH_PAYLOAD: begin
									payload_q <= dec_out;
									if (dec_out == '0) phase_q <= PH_TYPE;
								end
								default: begin
									if (act == ACT_HEADER) begin
										hk_q    <= new_hk;
										hbl_q   <= new_hbl;
										acc_q   <= '0;
										phase_q <= PH_HEADER;
									end
								end
							endcase
							if (act == ACT_PAYLOAD && !n_zero) begin
								payload_q <= act_n;
								phase_q   <= PH_PAYLOAD;
							end
							if (push) begin
								top_q   <= act_n;
								level_q <= level_q + LW'(1);
							end
						end
						if (need_end) begin
							state_q <= S_END;
						end else if (res_idle) begin
							res_sts_q <= res_idle_sts;
							res_len_q <= '0;
							state_q   <= S_EMIT;
						end
						// re-arm on the last byte unless an element end is still running
						if (!need_end && (res_idle || act == ACT_IGNORE) && last_byte) begin
							phase_q   <= PH_TYPE;
							bytes_q   <= '0;
							hbl_q     <= '0;
							hk_q      <= HK_RAW;
							acc_q     <= '0;
							payload_q <= '0;
							level_q   <= '0;
						end else if (res_idle) begin
							phase_q <= PH_DONE;
						end
					end
				end
				S_END: begin
					if (end_pop) begin
						level_q <= lvl_m1;
						state_q <= S_LOAD;
					end else begin
						if (level_q != '0) begin
							if (dec_out != '0) top_q <= dec_out;
							else level_q <= lvl_m1;
						end
						if (end_done) begin
							res_sts_q <= mlscan_pkg::STS_COMPLETE;
							res_len_q <= bytes_ext[OW-1:0];
						end else begin
							res_sts_q <= mlscan_pkg::STS_INCOMPLETE;
							res_len_q <= '0;
						end
						state_q <= (end_done || last_q) ? S_EMIT : S_IDLE;
						if (last_q) begin
							phase_q   <= PH_TYPE;
							bytes_q   <= '0;
							hbl_q     <= '0;
							hk_q      <= HK_RAW;
							acc_q     <= '0;
							payload_q <= '0;
							level_q   <= '0;
						end else if (end_done) begin
							phase_q <= PH_DONE;
						end
					end
				end
				S_LOAD: begin
					top_q   <= rdata_q;
					state_q <= S_END;
				end
				S_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q     <= 1'b1;
						status_q        <= res_sts_q;
						object_length_q <= res_len_q;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign object_length = object_length_q;

	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_EMIT)
		else $error("result appeared outside the emit stage");

	a_len_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != mlscan_pkg::STS_COMPLETE |-> object_length_q == '0)
		else $error("nonzero length on an error result");

	a_load_has_level: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> level_q != '0 && $past(state_q) == S_END)
		else $error("stack reload without an open level");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_DONE && !last_byte |=> phase_q == PH_DONE && state_q == S_IDLE)
		else $error("scanner left the done phase before the last byte");

endmodule

// ===== tb/msgpack_message_length_scanner_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msgpack_message_length_scanner_unit_tb
// Feeds byte streams to the length scanner: a few fixed corner messages,
// a nesting overflow, an output hold-off, then random well-formed objects
// mixed with truncated, padded and garbage messages. A behavioral scanner
// predicts each status and length, and every result is checked in order.
// Both sides idle and stall at random.
// ---------------------------------------------------------------------------
module msgpack_message_length_scanner_unit_tb;

	localparam int CLK_PERIOD  = 20;
	localparam int NEST        = mlscan_pkg::NEST_DEPTH_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 64;
	localparam int DRAIN_LIMIT = 20000;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 1300;

	localparam logic [7:0] T_FIXMAP  = 8'h80;
	localparam logic [7:0] T_RESV_C1 = 8'hc1;
	localparam logic [7:0] T_RESV_LO = 8'hc4;

	typedef logic [7:0] byte_q_t[$];
	typedef enum logic [1:0] {SC_TYPE, SC_HDR, SC_SKIP, SC_DONE} scan_t;
	typedef enum logic [2:0] {
		HK_RAW16, HK_RAW32, HK_ARR16, HK_ARR32, HK_MAP16, HK_MAP32
	} hdr_kind_t;
	typedef struct packed {
		logic             hit;
		mlscan_pkg::sts_t st;
	} verdict_t;
	typedef struct {
		mlscan_pkg::sts_t             st;
		logic [mlscan_pkg::LEN_W-1:0] len;
	} scan_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [7:0]                   byte_value = 8'h00;
	logic                         last_byte = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [1:0]                   status;
	logic [mlscan_pkg::LEN_W-1:0] object_length;

	msgpack_message_length_scanner_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.byte_value   (byte_value),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.object_length(object_length)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// scanner state as the block should hold it
	scan_t                        scan_st;
	logic [mlscan_pkg::LEN_W-1:0] seen_cnt;
	int                           hdr_left;
	hdr_kind_t                    hdr_kind;
	logic [31:0]                  hdr_len;
	logic [mlscan_pkg::CNT_W-1:0] skip_left;
	logic [mlscan_pkg::CNT_W-1:0] open_cnt [NEST];
	int                           open_lvls;

	scan_result_t scan_results_due[$];
	scan_result_t oldest;
	int           err_cnt = 0;
	bit           tx_gaps = 1'b0;
	bit           rx_jitter = 1'b0;
	int           hold_gen = 0;
	int           hold_seen = 0;
	int           hold_left = 0;
	int           stall_left = 0;
	int           cycle_cnt = 0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic verdict_t emit(mlscan_pkg::sts_t s);
		verdict_t v;
		v.hit = 1'b1;
		v.st = s;
		return v;
	endfunction

	function automatic void reset_scan();
		scan_st = SC_TYPE;
		seen_cnt = '0;
		hdr_left = 0;
		hdr_kind = HK_RAW16;
		hdr_len = '0;
		skip_left = '0;
		open_lvls = 0;
	endfunction

	// an element closed: pop every level whose count runs out
	function automatic verdict_t element_done();
		while (open_lvls > 0) begin
			open_cnt[open_lvls - 1] = open_cnt[open_lvls - 1] - 1'b1;
			if (open_cnt[open_lvls - 1] != 0)
				return '0;
			open_lvls--;
		end
		return emit(mlscan_pkg::STS_COMPLETE);
	endfunction

	function automatic verdict_t open_level(logic [mlscan_pkg::CNT_W-1:0] n);
		if (n == 0)
			return element_done();
		if (open_lvls >= NEST)
			return emit(mlscan_pkg::STS_TOO_DEEP);
		open_cnt[open_lvls] = n;
		open_lvls++;
		return '0;
	endfunction

	function automatic verdict_t skip_payload(logic [mlscan_pkg::CNT_W-1:0] n);
		if (n == 0)
			return element_done();
		skip_left = n;
		scan_st = SC_SKIP;
		return '0;
	endfunction

	function automatic void start_header(hdr_kind_t k, int n);
		hdr_kind = k;
		hdr_left = n;
		hdr_len = '0;
		scan_st = SC_HDR;
	endfunction

	function automatic verdict_t scan_type_byte(logic [7:0] t);
		if (t <= mlscan_pkg::T_POSFIX_MAX || t >= mlscan_pkg::T_NEGFIX_MIN ||
				t == mlscan_pkg::T_NIL || t == mlscan_pkg::T_FALSE ||
				t == mlscan_pkg::T_TRUE)
			return element_done();
		if (t < mlscan_pkg::T_FIXARR)
			return open_level({28'd0, t[3:0], 1'b0});
		if (t < mlscan_pkg::T_FIXRAW)
			return open_level({29'd0, t[3:0]});
		if (t < mlscan_pkg::T_NIL)
			return skip_payload({28'd0, t[4:0]});
		case (t)
			mlscan_pkg::T_FLOAT, mlscan_pkg::T_UINT32, mlscan_pkg::T_INT32:
				return skip_payload(33'd4);
			mlscan_pkg::T_DOUBLE, mlscan_pkg::T_UINT64, mlscan_pkg::T_INT64:
				return skip_payload(33'd8);
			mlscan_pkg::T_UINT8, mlscan_pkg::T_INT8: return skip_payload(33'd1);
			mlscan_pkg::T_UINT16, mlscan_pkg::T_INT16: return skip_payload(33'd2);
			mlscan_pkg::T_RAW16: begin
				start_header(HK_RAW16, 2);
				return '0;
			end
			mlscan_pkg::T_RAW32: begin
				start_header(HK_RAW32, 4);
				return '0;
			end
			mlscan_pkg::T_ARR16: begin
				start_header(HK_ARR16, 2);
				return '0;
			end
			mlscan_pkg::T_ARR32: begin
				start_header(HK_ARR32, 4);
				return '0;
			end
			mlscan_pkg::T_MAP16: begin
				start_header(HK_MAP16, 2);
				return '0;
			end
			mlscan_pkg::T_MAP32: begin
				start_header(HK_MAP32, 4);
				return '0;
			end
			default: return emit(mlscan_pkg::STS_INVALID);
		endcase
	endfunction

	function automatic verdict_t scan_header_byte(logic [7:0] b);
		hdr_len = {hdr_len[23:0], b};
		if (hdr_left != 0)
			hdr_left--;
		if (hdr_left != 0)
			return '0;
		scan_st = SC_TYPE;
		case (hdr_kind)
			HK_RAW16, HK_RAW32: return skip_payload({1'b0, hdr_len});
			HK_ARR16, HK_ARR32: return open_level({1'b0, hdr_len});
			default: return open_level({hdr_len, 1'b0});
		endcase
	endfunction

	function automatic verdict_t skip_byte();
		if (skip_left != 0)
			skip_left--;
		if (skip_left != 0)
			return '0;
		scan_st = SC_TYPE;
		return element_done();
	endfunction

	function automatic void scan_byte(logic [7:0] b, logic last);
		verdict_t     v;
		scan_result_t r;
		// after a result, bytes are dropped until the buffer ends
		if (scan_st == SC_DONE) begin
			if (last)
				reset_scan();
			return;
		end
		if (~&seen_cnt)
			seen_cnt++;
		case (scan_st)
			SC_HDR: v = scan_header_byte(b);
			SC_SKIP: v = skip_byte();
			default: v = scan_type_byte(b);
		endcase
		if (!v.hit && last)
			v = emit(mlscan_pkg::STS_INCOMPLETE);
		if (!v.hit)
			return;
		r.st = v.st;
		r.len = (v.st == mlscan_pkg::STS_COMPLETE) ? seen_cnt : '0;
		scan_results_due.push_back(r);
		if (last)
			reset_scan();
		else
			scan_st = SC_DONE;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t MISMATCH %s: got %0h want %0h", $realtime, what, got, want);
		err_cnt++;
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			scan_byte(byte_value, last_byte);
		if (arst_n && out_valid && !out_stall) begin
			if (scan_results_due.size() == 0) begin
				report_mismatch("result with none expected", 64'(status), 64'(0));
			end else begin
				oldest = scan_results_due.pop_front();
				if (status !== oldest.st)
					report_mismatch("status", 64'(status), 64'(oldest.st));
				if (object_length !== oldest.len)
					report_mismatch("object_length", 64'(object_length), 64'(oldest.len));
			end
		end
	end

	// receiver: long hold-off on request, otherwise random stall runs
	always @(posedge clk) begin
		if (hold_gen != hold_seen) begin
			hold_seen <= hold_gen;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (rx_jitter && $urandom_range(0, 3) == 0) begin
			stall_left <= pick_gap();
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("msgpack_message_length_scanner_unit_tb NOT OK");
		$finish;
	end

	task automatic send_item(logic [7:0] b, logic last);
		int gap;
		in_valid <= 1'b1;
		byte_value <= b;
		last_byte <= last;
		do
			@(posedge clk);
		while (in_stall);
		gap = tx_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_msg(input byte_q_t m);
		foreach (m[i])
			send_item(m[i], i == m.size() - 1);
	endtask

	task automatic wait_drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		// let the checker log the byte taken at the edge just passed
		@(posedge clk);
		while (scan_results_due.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic void gen_obj(ref byte_q_t q, input int depth);
		int         sel;
		int         n;
		bit         is_map;
		logic [7:0] code;
		sel = (depth >= 4) ? $urandom_range(0, 54) : $urandom_range(0, 99);
		if (sel < 20) begin
			case ($urandom_range(0, 4))
				0: q.push_back(8'($urandom_range(0, 127)));
				1: q.push_back(mlscan_pkg::T_NEGFIX_MIN | 8'($urandom_range(0, 31)));
				2: q.push_back(mlscan_pkg::T_NIL);
				3: q.push_back(mlscan_pkg::T_FALSE);
				default: q.push_back(mlscan_pkg::T_TRUE);
			endcase
		end else if (sel < 35) begin
			// float through int64 are contiguous codes
			code = mlscan_pkg::T_FLOAT + 8'($urandom_range(0, 9));
			case (code)
				mlscan_pkg::T_UINT8, mlscan_pkg::T_INT8: n = 1;
				mlscan_pkg::T_UINT16, mlscan_pkg::T_INT16: n = 2;
				mlscan_pkg::T_FLOAT, mlscan_pkg::T_UINT32, mlscan_pkg::T_INT32: n = 4;
				default: n = 8;
			endcase
			q.push_back(code);
			repeat (n) q.push_back(8'($urandom));
		end else if (sel < 45) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
			q.push_back(mlscan_pkg::T_FIXRAW | 8'(n));
			repeat (n) q.push_back(8'($urandom));
		end else if (sel < 55) begin
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 5);
			if ($urandom_range(0, 1)) begin
				q.push_back(mlscan_pkg::T_RAW16);
			end else begin
				q.push_back(mlscan_pkg::T_RAW32);
				q.push_back(8'h00);
				q.push_back(8'h00);
			end
			q.push_back(8'(n >> 8));
			q.push_back(8'(n));
			repeat (n) q.push_back(8'($urandom));
		end else begin
			is_map = ($urandom_range(0, 1) != 0);
			n = $urandom_range(0, 3);
			case ($urandom_range(0, 2))
				0: q.push_back((is_map ? T_FIXMAP : mlscan_pkg::T_FIXARR) | 8'(n));
				1: begin
					q.push_back(is_map ? mlscan_pkg::T_MAP16 : mlscan_pkg::T_ARR16);
					q.push_back(8'h00);
					q.push_back(8'(n));
				end
				default: begin
					q.push_back(is_map ? mlscan_pkg::T_MAP32 : mlscan_pkg::T_ARR32);
					repeat (3) q.push_back(8'h00);
					q.push_back(8'(n));
				end
			endcase
			repeat (is_map ? 2 * n : n) gen_obj(q, depth + 1);
		end
	endfunction

	task automatic test_corner_messages();
		tx_gaps = 1'b0;
		rx_jitter = 1'b0;
		send_msg('{mlscan_pkg::T_POSFIX_MAX});
		send_msg('{8'hff});
		// bytes after an invalid type byte are dropped until the last one
		send_msg('{T_RESV_C1, mlscan_pkg::T_NIL});
		send_msg('{T_FIXMAP});
		send_msg('{mlscan_pkg::T_FIXARR | 8'h02, 8'h00});
		// map count of twice 2^32-1 must not wrap
		send_msg('{mlscan_pkg::T_MAP32, 8'hff, 8'hff, 8'hff, 8'hff, mlscan_pkg::T_NIL});
		wait_drain();
	endtask

	task automatic test_nesting_overflow();
		byte_q_t m;
		repeat (NEST + 1) m.push_back(mlscan_pkg::T_FIXARR | 8'h01);
		send_msg(m);
		wait_drain();
	endtask

	task automatic test_output_backpressure();
		tx_gaps = 1'b0;
		rx_jitter = 1'b0;
		hold_gen <= hold_gen + 1;
		repeat (40) send_msg('{8'($urandom_range(0, 127))});
		wait_drain();
	endtask

	task automatic test_random_traffic(int target);
		byte_q_t msg;
		int      sent;
		int      mode;
		int      cut;
		sent = 0;
		tx_gaps = 1'b1;
		rx_jitter = 1'b1;
		while (sent < target) begin
			msg.delete();
			mode = $urandom_range(0, 99);
			if (mode < 8) begin
				// chain of one-element containers, sometimes past the depth limit
				repeat ($urandom_range(NEST - 3, NEST + 2)) begin
					case ($urandom_range(0, 2))
						0: msg.push_back(mlscan_pkg::T_FIXARR | 8'h01);
						1: begin
							msg.push_back(mlscan_pkg::T_ARR16);
							msg.push_back(8'h00);
							msg.push_back(8'h01);
						end
						default: begin
							msg.push_back(T_FIXMAP | 8'h01);
							msg.push_back(mlscan_pkg::T_NIL);
						end
					endcase
				end
				msg.push_back(mlscan_pkg::T_TRUE);
			end else if (mode < 14) begin
				if (mode < 11)
					msg.push_back(($urandom_range(0, 1)) ? T_RESV_C1 :
						T_RESV_LO + 8'($urandom_range(0, 5)));
				repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom));
			end else begin
				gen_obj(msg, 0);
			end
			mode = $urandom_range(0, 99);
			if (mode < 12 && msg.size() > 1) begin
				cut = $urandom_range(1, msg.size() - 1);
				while (msg.size() > cut)
					void'(msg.pop_back());
			end else if (mode < 26) begin
				repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom));
			end
			send_msg(msg);
			sent += msg.size();
			if ($urandom_range(0, 11) == 0) begin
				tx_gaps = $urandom_range(0, 3) != 0;
				rx_jitter = $urandom_range(0, 3) != 0;
			end
			if ($urandom_range(0, 24) == 0)
				wait_drain();
		end
		wait_drain();
	endtask

	initial begin
		reset_scan();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_messages();
		test_nesting_overflow();
		test_output_backpressure();
		test_random_traffic(RANDOM_ITEMS);
		if (scan_results_due.size() != 0)
			report_mismatch("results never produced", 64'(0), 64'(scan_results_due.size()));
		if (err_cnt == 0)
			$display("msgpack_message_length_scanner_unit_tb OK");
		else
			$display("msgpack_message_length_scanner_unit_tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/mlscan_pkg.sv
src/msgpack_message_length_scanner_unit.sv
tb/msgpack_message_length_scanner_unit_tb.sv
